[hdl/utdec_pkg.sv]
package utdec_pkg;

   // result classes
   localparam logic [2:0] CLASS_ASCII     = 3'd0;
   localparam logic [2:0] CLASS_DEGREE    = 3'd1;
   localparam logic [2:0] CLASS_TWO_BYTE  = 3'd2;
   localparam logic [2:0] CLASS_HANGUL    = 3'd3;
   localparam logic [2:0] CLASS_THREE     = 3'd4;
   localparam logic [2:0] CLASS_TRUNCATED = 3'd5;

   // continuation bytes still awaited
   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_ONE  = 2'd1;
   localparam logic [1:0] PEND_TWO  = 2'd2;

   // configuration register indexes
   localparam logic CSR_SCALE    = 1'b0;
   localparam logic CSR_ORIGIN_X = 1'b1;

   localparam logic [15:0] CODE_DEGREE      = 16'h00B0;
   localparam logic [15:0] CODE_HANGUL_LOW  = 16'hAC00;
   localparam logic [15:0] CODE_HANGUL_HIGH = 16'hD7A3;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [2:0]         char_class;
      logic [15:0]        code_point;
      logic signed [15:0] cursor_x;
      logic [11:0]        advance;
      logic [15:0]        total_width;
      logic               is_last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]         scale;
      logic signed [15:0] origin_x;
   } cfg_type;

endpackage

[hdl/utdec_decode.sv]
module utdec_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  utdec_pkg::req_type item,
   input  utdec_pkg::cfg_type cfg,
   output logic              produce,
   output utdec_pkg::rsp_type result
);

   logic [1:0]  pending_ff, pending_in;
   logic [15:0] partial_ff, partial_in;
   logic        three_ff, three_in;
   logic [15:0] wsum_ff, wsum_in;

   logic        done;
   logic [2:0]  cls;
   logic [15:0] code;
   logic [11:0] adv;
   logic [11:0] narrow;
   logic [11:0] wide;
   logic [7:0]  b;
   logic [17:0] cx_wide;
   logic [15:0] cx;
   logic [16:0] tot_wide;
   logic [15:0] tot;

   always_comb begin
      b          = item.text_byte;
      narrow     = {1'b0, cfg.scale, 3'b000};
      wide       = {cfg.scale, 4'b0000};
      pending_in = pending_ff;
      partial_in = partial_ff;
      three_in   = three_ff;
      done       = 1'b0;
      cls        = utdec_pkg::CLASS_ASCII;
      code       = 16'h0000;
      adv        = 12'h000;
      case (pending_ff)
         utdec_pkg::PEND_TWO: begin
            partial_in = partial_ff | {4'b0000, b[5:0], 6'b000000};
            pending_in = utdec_pkg::PEND_ONE;
         end
         utdec_pkg::PEND_ONE: begin
            code = partial_ff | {10'b0, b[5:0]};
            done = 1'b1;
            adv  = narrow;
            if (three_ff) begin
               if (code >= utdec_pkg::CODE_HANGUL_LOW && code <= utdec_pkg::CODE_HANGUL_HIGH) begin
                  cls = utdec_pkg::CLASS_HANGUL;
                  adv = wide;
               end else begin
                  cls = utdec_pkg::CLASS_THREE;
               end
            end else if (code == utdec_pkg::CODE_DEGREE) begin
               cls = utdec_pkg::CLASS_DEGREE;
            end else begin
               cls = utdec_pkg::CLASS_TWO_BYTE;
            end
            pending_in = utdec_pkg::PEND_NONE;
            partial_in = 16'h0000;
            three_in   = 1'b0;
         end
         default: begin
            // lead byte (also taken after the unused pending code)
            if (!b[7]) begin
               done = 1'b1;
               cls  = utdec_pkg::CLASS_ASCII;
               code = {8'h00, b};
               adv  = narrow;
            end else if (b[7:5] == 3'b110) begin
               partial_in = {5'b00000, b[4:0], 6'b000000};
               pending_in = utdec_pkg::PEND_ONE;
               three_in   = 1'b0;
            end else begin
               partial_in = {b[3:0], 12'h000};
               pending_in = utdec_pkg::PEND_TWO;
               three_in   = 1'b1;
            end
         end
      endcase

      // string cut off inside a sequence
      if (!done) begin
         cls  = utdec_pkg::CLASS_TRUNCATED;
         code = partial_in;
         adv  = 12'h000;
      end

      cx_wide = {{2{cfg.origin_x[15]}}, cfg.origin_x} + {2'b00, wsum_ff};
      if (!cx_wide[17] && cx_wide[16:15] != 2'b00) begin
         cx = 16'h7FFF;
      end else if (cx_wide[17] && cx_wide[16:15] != 2'b11) begin
         cx = 16'h8000;
      end else begin
         cx = cx_wide[15:0];
      end

      tot_wide = {1'b0, wsum_ff} + {5'b00000, adv};
      tot      = tot_wide[16] ? 16'hFFFF : tot_wide[15:0];

      produce            = done | item.end_of_string;
      result.char_class  = cls;
      result.code_point  = code;
      result.cursor_x    = cx;
      result.advance     = adv;
      result.total_width = tot;
      result.is_last     = item.end_of_string;

      wsum_in = done ? tot : wsum_ff;
      if (item.end_of_string) begin
         pending_in = utdec_pkg::PEND_NONE;
         partial_in = 16'h0000;
         three_in   = 1'b0;
         wsum_in    = 16'h0000;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= utdec_pkg::PEND_NONE;
         partial_ff <= 16'h0000;
         three_ff   <= 1'b0;
         wsum_ff    <= 16'h0000;
      end else if (step) begin
         pending_ff <= pending_in;
         partial_ff <= partial_in;
         three_ff   <= three_in;
         wsum_ff    <= wsum_in;
      end
   end

endmodule

[hdl/utf8_text_layout_decoder_core.sv]
// UTF-8 text layout decoder.
// req channel (valid/ready): one string byte per transaction, with an
// end_of_string flag on the final byte. rsp channel (valid/ready): one
// transaction per completed character with class, code point, cursor x,
// advance and running string width; a string cut off inside a sequence
// ends with a truncated-class transaction of zero advance.
// csr port: index 0 scale (0 stored as 1), index 1 signed origin_x; write
// only while the block is idle.
// A byte taken into the input register is decoded and its result loaded
// into the output register. Throughput: one byte per cycle while no result
// waits on rsp_ready, through the single decode-and-add path between them.
// Lead and middle bytes of a sequence give no result.
// Reset clears the string state, the pipeline valids, scale to 1 and
// origin_x to 0. When rsp_ready is low, the result holds in the output
// register; lead and middle bytes still pass, the next byte that completes
// a character waits in the input register, then req_ready drops until the
// result is taken.
module utf8_text_layout_decoder_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  utdec_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output utdec_pkg::rsp_type rsp_data,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [15:0]        csr_wr_data
);

   logic               in_vld_ff;
   utdec_pkg::req_type in_item_ff;
   logic               rsp_vld_ff;
   utdec_pkg::rsp_type rsp_item_ff;
   logic [7:0]         scale_ff;
   logic [15:0]        origin_ff;

   utdec_pkg::cfg_type cfg;
   utdec_pkg::rsp_type result;
   logic               produce;
   logic               out_free;
   logic               step;

   assign cfg.scale    = scale_ff;
   assign cfg.origin_x = origin_ff;
   assign out_free     = !rsp_vld_ff || rsp_ready;
   assign step         = in_vld_ff && (out_free || !produce);
   assign req_ready    = !in_vld_ff || step;
   assign rsp_valid    = rsp_vld_ff;
   assign rsp_data     = rsp_item_ff;

   utdec_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .item    (in_item_ff),
      .cfg     (cfg),
      .produce (produce),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_vld_ff <= 1'b1;
      end else if (step) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (step && produce) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && produce) begin
         rsp_item_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= 8'd1;
         origin_ff <= 16'h0000;
      end else if (csr_wr_en) begin
         case (csr_index)
            utdec_pkg::CSR_SCALE: begin
               scale_ff <= (csr_wr_data[7:0] == 8'd0) ? 8'd1 : csr_wr_data[7:0];
            end
            utdec_pkg::CSR_ORIGIN_X: begin
               origin_ff <= csr_wr_data;
            end
            default: begin
               scale_ff <= scale_ff;
            end
         endcase
      end
   end

   // zero scale is never stored
   a_scale_nonzero: assert property (@(posedge clock) disable iff (reset)
      scale_ff != 8'd0)
      else $error("scale register holds zero");

   a_trunc_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.char_class == utdec_pkg::CLASS_TRUNCATED |->
         rsp_data.is_last && rsp_data.advance == 12'h000)
      else $error("truncated result not last or with nonzero advance");

   a_total_covers_advance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {4'h0, rsp_data.advance} <= rsp_data.total_width)
      else $error("running width below character advance");

   // a producing decode must land in the output register
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      step && produce |=> rsp_valid)
      else $error("decoded result lost");

endmodule
